// ===== rtl/ddfr_pkg.sv =====
// Shared types and constants for the differential drive wheel command framer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ddfr_pkg;

   // Frame layout
   localparam int FRAME_BYTES = 14;
   localparam int POS_W       = 4;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   // Field widths
   localparam int VEL_W   = 16;
   localparam int REG_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;
   localparam int CSR_IDX_W = 2;

   // Default depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register reset values
   localparam logic [REG_W-1:0] GAIN_RESET       = 16'd20972;
   localparam logic [REG_W-1:0] HALF_TRACK_RESET = 16'd6881;
   localparam logic [REG_W-1:0] COUNTS_RESET     = 16'd22918;

   // Fixed frame bytes
   localparam logic [BYTE_W-1:0] SYNC_HEAD_0 = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_HEAD_1 = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_TAIL_0 = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_TAIL_1 = 8'h88;
   localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h00;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMMAND_GAIN     = 2'd0,
      CSR_HALF_TRACK_WIDTH = 2'd1,
      CSR_COUNTS_PER_SPEED = 2'd2
   } csr_index_type;

   // Wheel direction codes
   typedef enum logic [1:0] {
      DIR_FORWARD = 2'd0,
      DIR_REVERSE = 2'd1,
      DIR_STOPPED = 2'd2
   } dir_type;

   typedef struct packed {
      dir_type              dir;
      logic [COUNT_W-1:0]   count;
   } wheel_cmd_type;

   typedef struct packed {
      wheel_cmd_type left;
      wheel_cmd_type right;
   } frame_cmd_type;

   // Register values seen by the datapath
   typedef struct packed {
      logic [REG_W-1:0] command_gain;
      logic [REG_W-1:0] half_track_width;
      logic [REG_W-1:0] counts_per_speed;
   } csr_set_type;

endpackage

// ===== rtl/diff_drive_wheel_command_framer.sv =====
// Top level of the differential drive wheel command framer: registers, front, queue, back.
// Depends on ddfr_pkg, ddfr_front, ddfr_queue and ddfr_back.
//
//   channel   | ports                                        | transfer when
//   ----------+----------------------------------------------+------------------------
//   command   | push, full, req_linear/angular_velocity      | push && !full
//   frame     | empty, pop, rsp_frame_byte/position/last     | pop && !empty
//   registers | csr_valid, csr_ready, csr_index, csr_data    | csr_valid && csr_ready
//
// Each command yields 14 frame bytes, one per cycle while pop keeps taking them, so the
// sustained command rate is set by the single-byte output of the back part.
// The first frame byte passes through the six front stages, the queue and the output
// register before it shows on the result ports and can be popped.
// Commands are taken back to back until the front pipeline and the queue fill;
// a stalled pop holds the output byte and then backs up the queue.
// Reset is synchronous and clears all valid state and restores register defaults.
`timescale 1ns / 1ps

module diff_drive_wheel_command_framer #(
   parameter int QUEUE_DEPTH = ddfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [ddfr_pkg::VEL_W-1:0]     req_linear_velocity,
   input  logic signed [ddfr_pkg::VEL_W-1:0]     req_angular_velocity,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [ddfr_pkg::BYTE_W-1:0]           rsp_frame_byte,
   output logic [ddfr_pkg::POS_W-1:0]            rsp_byte_position,
   output logic                                  rsp_last_byte,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddfr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ddfr_pkg::REG_W-1:0]            csr_data
);
   import ddfr_pkg::*;

   csr_set_type   csr_ff, csr_in;
   logic          q_full, q_push, q_valid, q_pop;
   frame_cmd_type q_wr_data, q_rd_data;

   // Accept register writes every cycle; ignore unknown indexes
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COMMAND_GAIN:     csr_in.command_gain     = csr_data;
            CSR_HALF_TRACK_WIDTH: csr_in.half_track_width = csr_data;
            CSR_COUNTS_PER_SPEED: csr_in.counts_per_speed = csr_data;
            default:              csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.command_gain     <= GAIN_RESET;
         csr_ff.half_track_width <= HALF_TRACK_RESET;
         csr_ff.counts_per_speed <= COUNTS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ddfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_set    (csr_ff),
      .in_push    (push),
      .in_full    (full),
      .in_linear  (req_linear_velocity),
      .in_angular (req_angular_velocity),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wr_data)
   );

   ddfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_data)
   );

   ddfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .out_empty (empty),
      .out_pop   (pop),
      .out_byte  (rsp_frame_byte),
      .out_pos   (rsp_byte_position),
      .out_last  (rsp_last_byte)
   );

endmodule

// ===== rtl/ddfr_front.sv =====
// Front part: accepts velocity commands and computes per-wheel direction and count.
// Six-stage pipeline; depends on ddfr_pkg.
`timescale 1ns / 1ps

module ddfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  ddfr_pkg::csr_set_type         csr_set,
   input  logic                          in_push,
   output logic                          in_full,
   input  logic signed [ddfr_pkg::VEL_W-1:0] in_linear,
   input  logic signed [ddfr_pkg::VEL_W-1:0] in_angular,
   input  logic                          q_full,
   output logic                          q_push,
   output ddfr_pkg::frame_cmd_type       q_data
);
   import ddfr_pkg::*;

   localparam int PROD_W  = VEL_W + REG_W + 1;   // signed velocity times unsigned register
   localparam int SPEED_W = 50;
   localparam int MAG_W   = 48;
   localparam int HALF_W  = 24;
   localparam int PART_W  = HALF_W + REG_W;
   localparam int ACC_W   = PART_W + 1;
   localparam int SHIFT   = 18;

   logic [5:0] valid_ff, valid_in;
   logic       advance;

   logic signed [PROD_W-1:0]  lin_g_ff, lin_g_in, ang_g_ff, ang_g_in;
   logic signed [PROD_W-1:0]  base_ff, base_in;
   logic signed [SPEED_W-1:0] turn_ff, turn_in;
   logic signed [SPEED_W-1:0] base_ext;
   logic signed [SPEED_W-1:0] speed_ff [2];
   logic signed [SPEED_W-1:0] speed_in [2];
   dir_type                   dir4_ff [2];
   dir_type                   dir4_in [2];
   logic [MAG_W-1:0]          mag_ff [2];
   logic [MAG_W-1:0]          mag_in [2];
   dir_type                   dir5_ff [2];
   logic [PART_W-1:0]         hic_ff [2];
   logic [PART_W-1:0]         hic_in [2];
   logic [PART_W-1:0]         loc_ff [2];
   logic [PART_W-1:0]         loc_in [2];
   wheel_cmd_type             wheel_ff [2];
   wheel_cmd_type             wheel_in [2];
   logic [ACC_W-1:0]          acc [2];

   // Hold the whole pipeline while its last result waits for queue space
   assign advance  = !(valid_ff[5] && q_full);
   assign in_full  = !advance;
   assign q_push   = valid_ff[5] && advance;
   assign q_data   = '{left: wheel_ff[0], right: wheel_ff[1]};
   assign valid_in = {valid_ff[4:0], in_push};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: scale both commands by the gain
   assign lin_g_in = in_linear * $signed({1'b0, csr_set.command_gain});
   assign ang_g_in = in_angular * $signed({1'b0, csr_set.command_gain});

   // Stage 2: angular term times half track width
   assign base_in = lin_g_ff;
   assign turn_in = ang_g_ff * $signed({1'b0, csr_set.half_track_width});

   // Stage 3: form wheel speeds at scale 2^42
   assign base_ext    = {base_ff[PROD_W-1], base_ff, 16'h0000};
   assign speed_in[0] = base_ext + turn_ff;
   assign speed_in[1] = base_ext - turn_ff;

   // Stages 4 to 6 run per wheel
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         // Stage 4: sign and magnitude
         if (speed_ff[w] == '0) begin
            dir4_in[w] = DIR_STOPPED;
         end else if (speed_ff[w][SPEED_W-1]) begin
            dir4_in[w] = DIR_REVERSE;
         end else begin
            dir4_in[w] = DIR_FORWARD;
         end
         mag_in[w] = speed_ff[w][SPEED_W-1] ? MAG_W'(-speed_ff[w]) : MAG_W'(speed_ff[w]);
         // Stage 5: split the magnitude and scale both halves to counts
         hic_in[w] = mag_ff[w][MAG_W-1:HALF_W] * csr_set.counts_per_speed;
         loc_in[w] = mag_ff[w][HALF_W-1:0] * csr_set.counts_per_speed;
         // Stage 6: recombine, truncate and saturate
         acc[w] = ACC_W'(hic_ff[w]) + ACC_W'(loc_ff[w][PART_W-1:HALF_W]);
         wheel_in[w].dir = dir5_ff[w];
         if (|acc[w][ACC_W-1:SHIFT+COUNT_W]) begin
            wheel_in[w].count = '1;
         end else begin
            wheel_in[w].count = acc[w][SHIFT+COUNT_W-1:SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_g_ff <= lin_g_in;
         ang_g_ff <= ang_g_in;
         base_ff  <= base_in;
         turn_ff  <= turn_in;
         for (int w = 0; w < 2; w++) begin
            speed_ff[w] <= speed_in[w];
            dir4_ff[w]  <= dir4_in[w];
            mag_ff[w]   <= mag_in[w];
            dir5_ff[w]  <= dir4_ff[w];
            hic_ff[w]   <= hic_in[w];
            loc_ff[w]   <= loc_in[w];
            wheel_ff[w] <= wheel_in[w];
         end
      end
   end

endmodule

// ===== rtl/ddfr_queue.sv =====
// Short queue of wheel commands between the front and back parts.
// Depth set by parameter (at least 2); depends on ddfr_pkg.
`timescale 1ns / 1ps

module ddfr_queue #(
   parameter int DEPTH = ddfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  ddfr_pkg::frame_cmd_type  wr_data,
   output logic                     full,
   input  logic                     rd_en,
   output logic                     rd_valid,
   output ddfr_pkg::frame_cmd_type  rd_data
);
   import ddfr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/ddfr_back.sv =====
// Back part: serializes each queued wheel command into a 14-byte frame.
// Output register decouples the result channel; depends on ddfr_pkg.
`timescale 1ns / 1ps

module ddfr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  ddfr_pkg::frame_cmd_type        q_data,
   output logic                           q_pop,
   output logic                           out_empty,
   input  logic                           out_pop,
   output logic [ddfr_pkg::BYTE_W-1:0]    out_byte,
   output logic [ddfr_pkg::POS_W-1:0]     out_pos,
   output logic                           out_last
);
   import ddfr_pkg::*;

   localparam logic [POS_W-1:0] POS_HEAD_0 = 4'd0;
   localparam logic [POS_W-1:0] POS_HEAD_1 = 4'd1;
   localparam logic [POS_W-1:0] POS_DIR_L  = 4'd2;
   localparam logic [POS_W-1:0] POS_HI_L   = 4'd3;
   localparam logic [POS_W-1:0] POS_LO_L   = 4'd4;
   localparam logic [POS_W-1:0] POS_DIR_R  = 4'd5;
   localparam logic [POS_W-1:0] POS_HI_R   = 4'd6;
   localparam logic [POS_W-1:0] POS_LO_R   = 4'd7;
   localparam logic [POS_W-1:0] POS_TAIL_0 = 4'd12;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [POS_W-1:0]  opos_ff;
   logic              last_ff;
   logic              load;
   logic              at_last;

   // Pick the frame byte for the current position
   function automatic logic [BYTE_W-1:0] frame_byte(frame_cmd_type cmd,
                                                    logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] b;
      case (pos)
         POS_HEAD_0: b = SYNC_HEAD_0;
         POS_HEAD_1: b = SYNC_HEAD_1;
         POS_DIR_L:  b = {6'b0, cmd.left.dir};
         POS_HI_L:   b = cmd.left.count[15:8];
         POS_LO_L:   b = cmd.left.count[7:0];
         POS_DIR_R:  b = {6'b0, cmd.right.dir};
         POS_HI_R:   b = cmd.right.count[15:8];
         POS_LO_R:   b = cmd.right.count[7:0];
         POS_TAIL_0: b = SYNC_TAIL_0;
         POS_LAST:   b = SYNC_TAIL_1;
         default:    b = PAD_BYTE;
      endcase
      return b;
   endfunction

   // Refill the output register when it is free or being taken
   assign load    = !out_valid_ff || out_pop;
   assign at_last = (pos_ff == POS_LAST);
   assign q_pop   = load && q_valid && at_last;

   always_comb begin
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      byte_in      = frame_byte(q_data, pos_ff);
      if (load) begin
         out_valid_in = q_valid;
         if (q_valid) begin
            pos_in = at_last ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && q_valid) begin
         byte_ff <= byte_in;
         opos_ff <= pos_ff;
         last_ff <= at_last;
      end
   end

   assign out_empty = !out_valid_ff;
   assign out_byte  = byte_ff;
   assign out_pos   = opos_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/ddfr_checker.sv =====
// Port-level checks on the frame output of the wheel command framer, bound to the top.
// Depends on ddfr_pkg and diff_drive_wheel_command_framer.
`timescale 1ns / 1ps

module ddfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            empty,
   input logic                            pop,
   input logic [ddfr_pkg::BYTE_W-1:0]     rsp_frame_byte,
   input logic [ddfr_pkg::POS_W-1:0]      rsp_byte_position,
   input logic                            rsp_last_byte
);
   import ddfr_pkg::*;

   // Reset drains the output
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("output not empty after reset");

   // Last-byte flag marks the final position only
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last_byte == (rsp_byte_position == POS_LAST)))
      else $error("last_byte disagrees with byte_position");

   // Frame bytes advance one position per transaction within a frame
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_byte) |=>
      (empty || rsp_byte_position == $past(rsp_byte_position) + 4'd1))
      else $error("byte_position skipped or repeated");

   // A waiting byte holds until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_frame_byte)
                            && $stable(rsp_byte_position)))
      else $error("stalled frame byte changed");

endmodule

bind diff_drive_wheel_command_framer ddfr_checker u_ddfr_checker (
   .clock             (clock),
   .reset             (reset),
   .empty             (empty),
   .pop               (pop),
   .rsp_frame_byte    (rsp_frame_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_last_byte     (rsp_last_byte)
);
